// ----- rtl/core/dht_pkg.sv -----
// Shared constants and codes for the double-hashing table.
package dht_pkg;

	localparam int OP_W       = 2;
	localparam int KEY_W      = 31;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 4;
	localparam int MARK_W     = 2;

	typedef logic [OP_W-1:0]     opcode_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [MARK_W-1:0]   mark_t;

	localparam opcode_t OP_INSERT = 2'd0;
	localparam opcode_t OP_SEARCH = 2'd1;
	localparam opcode_t OP_DELETE = 2'd2;
	localparam opcode_t OP_NOP    = 2'd3;

	localparam mark_t MARK_EMPTY   = 2'd0;
	localparam mark_t MARK_USED    = 2'd1;
	localparam mark_t MARK_DELETED = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;

endpackage

// ----- rtl/core/dht_req_if.sv -----
// Request channel: opcode and key with valid/ready.
interface dht_req_if;
	logic                        valid;
	logic                        ready;
	logic [dht_pkg::OP_W-1:0]    opcode;
	logic [dht_pkg::KEY_W-1:0]   key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink   (input valid, input opcode, input key, output ready);
endinterface

// ----- rtl/core/dht_rsp_if.sv -----
// Response channel: status and slot index with valid/ready.
interface dht_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [dht_pkg::STATUS_W-1:0]     status;
	logic [dht_pkg::SLOT_OUT_W-1:0]   slot_index;

	modport source (output valid, output status, output slot_index, input ready);
	modport sink   (input valid, input status, input slot_index, output ready);
endinterface

// ----- rtl/core/dht_hash.sv -----
// Residue unit: key mod N and 1 + key mod (N-2) by reciprocal multiplication.
module dht_hash #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dht_pkg::KEY_W-1:0]      key,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] base,
	output logic [$clog2(TABLE_SLOTS)-1:0] step
);

	localparam int IDX_W  = $clog2(TABLE_SLOTS);
	localparam int KEY_W  = dht_pkg::KEY_W;
	localparam int REC_W  = KEY_W + 1;
	localparam int PROD_W = KEY_W + REC_W;
	localparam int DIV_A  = TABLE_SLOTS;
	localparam int DIV_B  = TABLE_SLOTS - 2;
	localparam int SH_A   = KEY_W + $clog2(DIV_A);
	localparam int SH_B   = KEY_W + $clog2(DIV_B);
	// ceil(2^SH / d) gives the exact quotient for every key below 2^KEY_W
	localparam logic [REC_W-1:0] REC_A =
		REC_W'(((64'd1 << SH_A) + 64'(DIV_A) - 64'd1) / 64'(DIV_A));
	localparam logic [REC_W-1:0] REC_B =
		REC_W'(((64'd1 << SH_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B));
	localparam logic [IDX_W-1:0] DIV_A_LO = IDX_W'(DIV_A);
	localparam logic [IDX_W-1:0] DIV_B_LO = IDX_W'(DIV_B);

	logic [KEY_W-1:0]  key_s1;
	logic              valid_s1;
	logic [IDX_W-1:0]  key_lo_s2;
	logic [IDX_W-1:0]  quo_a_s2;
	logic [IDX_W-1:0]  quo_b_s2;
	logic              valid_s2;
	logic [IDX_W-1:0]  rem_a_q;
	logic [IDX_W-1:0]  rem_b_q;
	logic              done_q;
	logic [PROD_W-1:0] prod_a;
	logic [PROD_W-1:0] prod_b;

	assign prod_a = key_s1 * REC_A;
	assign prod_b = key_s1 * REC_B;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	// residue fits in IDX_W bits, so only the low quotient bits are kept
	always_ff @(posedge clk) begin
		if (start) begin
			key_s1 <= key;
		end
		if (valid_s1) begin
			key_lo_s2 <= key_s1[IDX_W-1:0];
			quo_a_s2  <= prod_a[SH_A +: IDX_W];
			quo_b_s2  <= prod_b[SH_B +: IDX_W];
		end
		if (valid_s2) begin
			rem_a_q <= key_lo_s2 - quo_a_s2 * DIV_A_LO;
			rem_b_q <= key_lo_s2 - quo_b_s2 * DIV_B_LO;
		end
	end

	assign done = done_q;
	assign base = rem_a_q;
	assign step = rem_b_q + 1'b1;

endmodule

// ----- rtl/core/double_hash_table.sv -----
// Double-hashing table: probe sequencer around a single slot memory.
//
//  channel | dir | fields              | transfer when
//  --------+-----+---------------------+--------------------------
//  req     | in  | opcode, key         | req.valid && req.ready
//  rsp     | out | status, slot_index  | rsp.valid && rsp.ready
//
// One item at a time: accept, residue computation (key register, reciprocal
// multiply, remainder), then one memory read per probe (P probes, P <= TABLE_SLOTS),
// then write-back and loading of the result. A no-op goes from accept straight to
// the result load.
// The probe loop is set by the one read port of the slot memory.
// After reset the marks are cleared one slot a cycle, with req.ready low. A waiting
// result stalls only the write-back cycle of the next item.
module double_hash_table #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	dht_req_if.sink   req,
	dht_rsp_if.source rsp
);

	localparam int IDX_W   = $clog2(TABLE_SLOTS);
	localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
	localparam int KEY_W   = dht_pkg::KEY_W;
	localparam int MARK_W  = dht_pkg::MARK_W;
	localparam int OUT_W   = dht_pkg::SLOT_OUT_W;
	localparam int ENTRY_W = MARK_W + KEY_W;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_HASH   = 3'd2;
	localparam logic [2:0] S_PROBE  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       clr_addr_q;
	dht_pkg::opcode_t       op_q;
	logic [KEY_W-1:0]       key_q;
	logic [IDX_W-1:0]       step_q;
	logic [IDX_W-1:0]       slot_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   rd_valid_s1;
	logic [IDX_W-1:0]       rd_slot_s1;
	logic [ENTRY_W-1:0]     rd_data_s1;
	dht_pkg::status_t       res_status_q;
	logic [IDX_W-1:0]       res_slot_q;
	logic                   res_we_q;
	dht_pkg::mark_t         res_mark_q;
	logic                   rsp_valid_q;
	dht_pkg::status_t       rsp_status_q;
	logic [OUT_W-1:0]       rsp_slot_q;

	logic [ENTRY_W-1:0]     mem_q [TABLE_SLOTS];

	logic                   hash_start;
	logic                   hash_done;
	logic [IDX_W-1:0]       hash_base;
	logic [IDX_W-1:0]       hash_step;
	dht_pkg::mark_t         rd_mark;
	logic [KEY_W-1:0]       rd_key;
	logic                   hit;
	logic                   miss;
	logic                   exhausted;
	logic                   issue;
	logic [IDX_W:0]         slot_sum;
	logic [IDX_W-1:0]       slot_next;
	logic                   out_free;
	logic                   load_rsp;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [ENTRY_W-1:0]     mem_wdata;

	dht_hash #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req.key),
		.done   (hash_done),
		.base   (hash_base),
		.step   (hash_step)
	);

	assign hash_start = (state_q == S_IDLE) && req.valid && (req.opcode != dht_pkg::OP_NOP);

	assign rd_mark = rd_data_s1[ENTRY_W-1 -: MARK_W];
	assign rd_key  = rd_data_s1[KEY_W-1:0];

	always_comb begin
		if (op_q == dht_pkg::OP_INSERT) begin
			hit  = rd_valid_s1 && (rd_mark != dht_pkg::MARK_USED);
			miss = 1'b0;
		end else begin
			hit  = rd_valid_s1 && (rd_mark == dht_pkg::MARK_USED) && (rd_key == key_q);
			miss = rd_valid_s1 && (rd_mark == dht_pkg::MARK_EMPTY);
		end
	end

	// all probes issued and the last one decided nothing
	assign exhausted = (cnt_q == CNT_W'(TABLE_SLOTS)) && !hit && !miss;
	assign issue     = (state_q == S_PROBE) && (cnt_q != CNT_W'(TABLE_SLOTS)) && !hit && !miss;

	// step < N and slot < N, so one conditional subtract wraps the sum
	assign slot_sum  = {1'b0, slot_q} + {1'b0, step_q};
	assign slot_next = (slot_sum >= (IDX_W+1)'(TABLE_SLOTS))
		? IDX_W'(slot_sum - (IDX_W+1)'(TABLE_SLOTS)) : slot_sum[IDX_W-1:0];

	assign out_free = !rsp_valid_q || rsp.ready;
	assign load_rsp = (state_q == S_FINISH) && out_free;

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = {dht_pkg::MARK_EMPTY, KEY_W'(0)};
		end else begin
			mem_we    = load_rsp && res_we_q;
			mem_waddr = res_slot_q;
			mem_wdata = {res_mark_q, key_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_data_s1 <= mem_q[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == IDX_W'(TABLE_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						if (req.opcode == dht_pkg::OP_NOP) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						cnt_q       <= '0;
						rd_valid_s1 <= 1'b0;
						state_q     <= S_PROBE;
					end
				end
				S_PROBE: begin
					rd_valid_s1 <= issue;
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (hit || miss || exhausted) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register: loads on write-back, empties on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q         <= req.opcode;
				key_q        <= req.key;
				res_status_q <= dht_pkg::ST_NOT_FOUND;
				res_slot_q   <= '0;
				res_we_q     <= 1'b0;
			end
			S_HASH: begin
				slot_q <= hash_base;
				step_q <= hash_step;
			end
			S_PROBE: begin
				if (issue) begin
					rd_slot_s1 <= slot_q;
					slot_q     <= slot_next;
				end
				if (hit) begin
					res_status_q <= dht_pkg::ST_OK;
					res_slot_q   <= rd_slot_s1;
					res_we_q     <= (op_q != dht_pkg::OP_SEARCH);
					res_mark_q   <= (op_q == dht_pkg::OP_INSERT)
						? dht_pkg::MARK_USED : dht_pkg::MARK_DELETED;
				end else if (miss || exhausted) begin
					res_status_q <= (op_q == dht_pkg::OP_INSERT)
						? dht_pkg::ST_FULL : dht_pkg::ST_NOT_FOUND;
					res_slot_q   <= '0;
					res_we_q     <= 1'b0;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					rsp_status_q <= res_status_q;
					rsp_slot_q   <= OUT_W'(res_slot_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.slot_index = rsp_slot_q;

	a_no_write_while_probing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> !mem_we)
		else $error("slot memory written during probe loop");

	a_probe_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> ({1'b0, slot_q} < (IDX_W+1)'(TABLE_SLOTS)))
		else $error("probe slot out of table range");

	a_probe_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_SLOTS))
		else $error("more probes than slots");

	a_error_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q != dht_pkg::ST_OK)) |-> (rsp_slot_q == '0))
		else $error("nonzero slot index on failed operation");

endmodule
